// ===== hdl/mpq_pkg.sv =====
// mpq_pkg: shared types and constants of the max priority queue.
// Used by mpq_cell, max_priority_queue and mpq_checker; no dependencies.
`default_nettype none

package mpq_pkg;

  localparam int VALUE_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_PEEK    = 2'd1,
    FUNC_EXTRACT = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic extract;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/mpq_cell.sv =====
// mpq_cell: one slot of the sorted chain (largest value in cell 0).
// Depends on mpq_pkg for the command struct.
`default_nettype none

module mpq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                         clk,
  input  mpq_pkg::cell_ctl_t          ctl,
  input  wire                         occupied,
  input  wire signed [DATA_WIDTH-1:0] ins_value,
  input  wire signed [DATA_WIDTH-1:0] upper_data,
  input  wire                         upper_gt,
  input  wire signed [DATA_WIDTH-1:0] lower_data,
  output logic signed [DATA_WIDTH-1:0] data,
  output logic                         gt
);

  logic signed [DATA_WIDTH-1:0] data_next;

  // new value belongs at or above this slot
  assign gt = !occupied || (ins_value > data);

  always_comb begin
    data_next = data;
    if (ctl.insert) begin
      if (gt) begin
        data_next = upper_gt ? upper_data : ins_value;
      end
    end else if (ctl.extract) begin
      data_next = lower_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ===== hdl/max_priority_queue.sv =====
// max_priority_queue: bounded max priority queue built as a sorted chain of cells.
// Depends on mpq_pkg and mpq_cell.
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tuser[1:0] func, s_tdata[31:0] value
//  m       | out | m_tvalid/m_tready  | m_tdata: result_value, status, count, is_empty
//  cfg     | in  | cfg_wr_en          | cfg_wr_data[4:0] capacity_limit
//
// Each request is first registered; once m is free, the cell chain inserts
// (parallel compare) or shifts up (extract) and the result is loaded.
// The max is always in cell 0. Reset clears the count and sets capacity 16.
// A request is taken while a result waits; it is processed once m is free.
`default_nettype none

module max_priority_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [mpq_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] value
  input  wire [1:0]  s_tuser,   // [1:0] func
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [mpq_pkg::OUT_DATA_W-1:0] m_tdata,   // [31:0] result_value,
                                // [33:32] status, [38:34] count, [39] is_empty
  input  wire        cfg_wr_en,
  input  wire [4:0]  cfg_wr_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > mpq_pkg::CAP_W) ? CNT_W : mpq_pkg::CAP_W;

  logic [mpq_pkg::CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic                        pend;
  mpq_pkg::func_t              req_func;
  logic signed [DATA_WIDTH-1:0] req_value;
  logic signed [mpq_pkg::VALUE_W-1:0] in_value;

  mpq_pkg::cell_ctl_t           ctl;
  logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                         cell_gt   [DEPTH];

  logic                         fire;
  logic                         full;
  mpq_pkg::status_t             res_status;
  logic [mpq_pkg::VALUE_W-1:0]  res_value;

  assign in_value = s_tdata[mpq_pkg::VALUE_W-1:0];
  assign s_tready = !pend;
  assign fire     = pend && (!m_tvalid || m_tready);
  assign full     = (count == CNT_W'(DEPTH)) ||
                    (CMP_W'(count) >= CMP_W'(capacity));

  always_comb begin
    ctl        = '0;
    count_next = count;
    res_status = mpq_pkg::STATUS_OK;
    res_value  = '0;
    unique case (req_func) inside
      mpq_pkg::FUNC_INSERT: begin
        if (full) begin
          res_status = mpq_pkg::STATUS_FULL;
        end else begin
          ctl.insert = fire;
          count_next = count + 1'b1;
        end
      end
      mpq_pkg::FUNC_PEEK, mpq_pkg::FUNC_EXTRACT: begin
        if (count == '0) begin
          res_status = mpq_pkg::STATUS_EMPTY;
        end else begin
          res_value = mpq_pkg::VALUE_W'(cell_data[0]);
          if (req_func == mpq_pkg::FUNC_EXTRACT) begin
            ctl.extract = fire;
            count_next  = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= mpq_pkg::CAP_RESET;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        pend <= 1'b1;
      end else if (fire) begin
        pend <= 1'b0;
      end
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_func  <= mpq_pkg::func_t'(s_tuser);
      req_value <= DATA_WIDTH'(in_value);
    end
    if (fire) begin
      m_tdata <= {(count_next == '0),
                  mpq_pkg::COUNT_W'(count_next),
                  res_status,
                  res_value};
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] up_d;
    logic signed [DATA_WIDTH-1:0] lo_d;
    logic                         up_gt;

    if (i == 0) begin : g_head
      assign up_d  = req_value;
      assign up_gt = 1'b0;
    end else begin : g_body
      assign up_d  = cell_data[i-1];
      assign up_gt = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign lo_d = cell_data[i];
    end else begin : g_mid
      assign lo_d = cell_data[i+1];
    end

    mpq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CNT_W'(i) < count),
      .ins_value  (req_value),
      .upper_data (up_d),
      .upper_gt   (up_gt),
      .lower_data (lo_d),
      .data       (cell_data[i]),
      .gt         (cell_gt[i])
    );
  end

endmodule

`default_nettype wire

// ===== hdl/mpq_checker.sv =====
// mpq_checker: port-level checks of max_priority_queue, bound to the top level.
// Depends on mpq_pkg for status codes.
`default_nettype none

module mpq_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [39:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is pending");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39] == (m_tdata[38:34] == 5'd0))
    else $error("is_empty disagrees with count");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] == mpq_pkg::STATUS_EMPTY
      |-> m_tdata[31:0] == 32'd0 && m_tdata[39])
    else $error("empty status with data or entries");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'd3)
    else $error("undefined status code");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
